[rtl/core/lirs_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the resampler.
package lirs_pkg;

	localparam int PHASE_FRAC_BITS = 20;
	localparam int PHASE_W         = PHASE_FRAC_BITS + 5;
	localparam int STEP_W          = 25;
	localparam int MAX_CHANNELS    = 8;
	localparam int CHAN_W          = 3;
	localparam int CHAN_CNT_W      = 4;
	localparam int MAX_BURST       = 8;
	localparam int BURST_W         = 3;
	localparam int WORD_W          = 32;
	localparam int PCM_W           = 16;
	localparam int Q8_W            = 32;
	localparam int FMAG_W          = 39;
	localparam int PROD_W          = Q8_W + PHASE_FRAC_BITS;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 25;

	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_FORMAT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

	localparam logic FMT_INT16   = 1'b0;
	localparam logic FMT_FLOAT32 = 1'b1;

	localparam logic [STEP_W-1:0]     STEP_RESET   = 25'd1048576;
	localparam logic [CHAN_CNT_W-1:0] CHAN_RESET   = 4'd1;
	localparam logic [PHASE_W-1:0]    PHASE_ONE    = 25'd1 << PHASE_FRAC_BITS;
	localparam logic [PHASE_W-1:0]    PHASE_MAX    = '1;
	localparam logic [7:0]            FLT_EXP_BIAS = 8'd142;
	localparam logic [14:0]           FLT_SCALE    = 15'd32767;
	localparam logic [Q8_W-1:0]       Q8_POS_LIM   = 32'h7FFF_FFFF;
	localparam logic [Q8_W-1:0]       Q8_NEG_LIM   = 32'h8000_0000;
	localparam logic signed [24:0]    OUT_HI_Q8    = 25'sd8388352;
	localparam logic signed [24:0]    OUT_LO_Q8    = -25'sd8388608;

	typedef struct packed {
		logic take;   // input beat accepted
		logic cvt;    // float mantissa scale
		logic sat;    // normalize and saturate into right sample
		logic skip;   // frame gives no output: commit left/phase
		logic diff;   // latch |right-left| and start a burst
		logic mul;    // difference times phase fraction
		logic emit;   // load output register and advance phase
	} lirs_cmd_t;

	typedef struct packed {
		logic idx_zero;
		logic have_left;
		logic phase_ge_one;
		logic burst_last;
		logic out_free;
	} lirs_stat_t;

endpackage

[rtl/core/lirs_ctrl.sv]
// Sequencer for conversion, burst interpolation and output handoff.
module lirs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  lirs_pkg::lirs_stat_t stat,
	output lirs_pkg::lirs_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CVT  = 3'd1;
	localparam logic [2:0] ST_SAT  = 3'd2;
	localparam logic [2:0] ST_DEC  = 3'd3;
	localparam logic [2:0] ST_MUL  = 3'd4;
	localparam logic [2:0] ST_EMIT = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					if (stat.idx_zero) state_d = ST_CVT;
				end
			end
			ST_CVT: begin
				cmd.cvt = 1'b1;
				state_d = ST_SAT;
			end
			ST_SAT: begin
				cmd.sat = 1'b1;
				state_d = ST_DEC;
			end
			ST_DEC: begin
				if (!stat.have_left || stat.phase_ge_one) begin
					cmd.skip = 1'b1;
					state_d  = ST_IDLE;
				end else begin
					cmd.diff = 1'b1;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				// hold until the output register can take the beat
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = stat.burst_last ? ST_IDLE : ST_MUL;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/core/lirs_datapath.sv]
// Configuration registers, sample conversion, interpolation datapath and output register.
module lirs_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [lirs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lirs_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [lirs_pkg::WORD_W-1:0]          sample_word,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [lirs_pkg::PCM_W-1:0]    pcm_sample,
	output logic                                 last,
	input  lirs_pkg::lirs_cmd_t                  cmd,
	output lirs_pkg::lirs_stat_t                 stat
);

	// configuration
	logic [lirs_pkg::STEP_W-1:0]     step_q;
	logic                            fmt_q;
	logic [lirs_pkg::CHAN_CNT_W-1:0] chan_cnt_q;

	// frame state
	logic [lirs_pkg::CHAN_W-1:0]     chan_idx_q;
	logic                            have_left_q;
	logic signed [lirs_pkg::Q8_W-1:0] left_q;
	logic signed [lirs_pkg::Q8_W-1:0] right_q;
	logic [lirs_pkg::PHASE_W-1:0]    phase_q;
	logic [lirs_pkg::BURST_W-1:0]    burst_cnt_q;
	logic [lirs_pkg::WORD_W-1:0]     word_q;

	// conversion and multiply registers
	logic [lirs_pkg::FMAG_W-1:0]     fmag_q;
	logic [7:0]                      fexp_q;
	logic                            fneg_q;
	logic                            fnan_q;
	logic                            finf_q;
	logic [lirs_pkg::Q8_W-1:0]       dmag_q;
	logic                            dneg_q;
	logic [lirs_pkg::PROD_W-1:0]     prod_q;

	// output register
	logic                            out_valid_q;
	logic signed [lirs_pkg::PCM_W-1:0] pcm_q;
	logic                            last_q;

	assign out_valid  = out_valid_q;
	assign pcm_sample = pcm_q;
	assign last       = last_q;

	// channel index advance with clamped channel count
	logic [lirs_pkg::CHAN_CNT_W-1:0] cc_eff;
	logic [lirs_pkg::CHAN_CNT_W-1:0] idx_inc;
	logic [lirs_pkg::CHAN_W-1:0]     idx_next;

	always_comb begin
		if (chan_cnt_q == '0)
			cc_eff = 4'd1;
		else if (chan_cnt_q > 4'(lirs_pkg::MAX_CHANNELS))
			cc_eff = 4'(lirs_pkg::MAX_CHANNELS);
		else
			cc_eff = chan_cnt_q;
		idx_inc  = {1'b0, chan_idx_q} + 4'd1;
		idx_next = (idx_inc >= cc_eff) ? '0 : idx_inc[lirs_pkg::CHAN_W-1:0];
	end

	// float front end: mantissa times 32767
	logic [7:0]  w_exp;
	logic [22:0] w_man;
	logic [23:0] man_eff;

	always_comb begin
		w_exp   = word_q[30:23];
		w_man   = word_q[22:0];
		man_eff = (w_exp == 8'd0) ? {1'b0, w_man} : {1'b1, w_man};
	end

	// normalize and saturate
	logic [lirs_pkg::Q8_W-1:0] lim;
	logic [7:0]                exp_eff;
	logic [7:0]                lsh;
	logic [7:0]                rsh;
	logic [69:0]               shl;
	logic [lirs_pkg::FMAG_W-1:0] shr;
	logic [lirs_pkg::Q8_W-1:0] fmag_sat;
	logic [lirs_pkg::Q8_W-1:0] flt_q8;
	logic [lirs_pkg::Q8_W-1:0] int_q8;
	logic [lirs_pkg::Q8_W-1:0] right_d;

	always_comb begin
		lim     = fneg_q ? lirs_pkg::Q8_NEG_LIM : lirs_pkg::Q8_POS_LIM;
		exp_eff = (fexp_q == 8'd0) ? 8'd1 : fexp_q;
		lsh     = exp_eff - lirs_pkg::FLT_EXP_BIAS;
		rsh     = lirs_pkg::FLT_EXP_BIAS - exp_eff;
		shl     = {31'd0, fmag_q} << lsh[4:0];
		shr     = (rsh >= 8'd39) ? '0 : (fmag_q >> rsh[5:0]);
		if (exp_eff >= lirs_pkg::FLT_EXP_BIAS) begin
			if (fmag_q != '0 && (lsh > 8'd31 || shl > {38'd0, lim}))
				fmag_sat = lim;
			else
				fmag_sat = shl[lirs_pkg::Q8_W-1:0];
		end else begin
			fmag_sat = (shr > {7'd0, lim}) ? lim : shr[lirs_pkg::Q8_W-1:0];
		end
		if (fnan_q)
			flt_q8 = '0;
		else if (finf_q)
			flt_q8 = fneg_q ? (-lim) : lim;
		else
			flt_q8 = fneg_q ? (-fmag_sat) : fmag_sat;
		int_q8  = {{8{word_q[15]}}, word_q[15:0], 8'd0};
		right_d = (fmt_q == lirs_pkg::FMT_FLOAT32) ? flt_q8 : int_q8;
	end

	// difference magnitude
	logic signed [lirs_pkg::Q8_W:0] diff;
	logic [lirs_pkg::Q8_W:0]        diff_abs;

	always_comb begin
		diff     = {right_q[lirs_pkg::Q8_W-1], right_q} - {left_q[lirs_pkg::Q8_W-1], left_q};
		diff_abs = diff[lirs_pkg::Q8_W] ? (-diff) : diff;
	end

	// add, clamp, round half away from zero
	logic [lirs_pkg::Q8_W-1:0]        m;
	logic signed [33:0]               v;
	logic signed [24:0]               vc;
	logic [24:0]                      vmag;
	logic [24:0]                      vrnd;
	logic signed [lirs_pkg::PCM_W-1:0] pcm_d;

	always_comb begin
		m = prod_q[lirs_pkg::PROD_W-1:lirs_pkg::PHASE_FRAC_BITS];
		if (dneg_q)
			v = {{2{left_q[lirs_pkg::Q8_W-1]}}, left_q} - $signed({2'b00, m});
		else
			v = {{2{left_q[lirs_pkg::Q8_W-1]}}, left_q} + $signed({2'b00, m});
		if (v > 34'(lirs_pkg::OUT_HI_Q8))
			vc = lirs_pkg::OUT_HI_Q8;
		else if (v < 34'(lirs_pkg::OUT_LO_Q8))
			vc = lirs_pkg::OUT_LO_Q8;
		else
			vc = v[24:0];
		vmag  = vc[24] ? (-vc) : vc;
		vrnd  = (vmag + 25'd128) >> 8;
		pcm_d = vc[24] ? (-vrnd[lirs_pkg::PCM_W-1:0]) : vrnd[lirs_pkg::PCM_W-1:0];
	end

	// phase advance with saturation
	logic [lirs_pkg::PHASE_W:0]   phase_sum;
	logic [lirs_pkg::PHASE_W-1:0] phase_adv;
	logic                         adv_ge_one;

	always_comb begin
		phase_sum  = {1'b0, phase_q} + {1'b0, step_q};
		phase_adv  = phase_sum[lirs_pkg::PHASE_W] ? lirs_pkg::PHASE_MAX
		                                         : phase_sum[lirs_pkg::PHASE_W-1:0];
		adv_ge_one = (phase_adv >= lirs_pkg::PHASE_ONE);
	end

	always_comb begin
		stat.idx_zero     = (chan_idx_q == '0);
		stat.have_left    = have_left_q;
		stat.phase_ge_one = (phase_q >= lirs_pkg::PHASE_ONE);
		stat.burst_last   = adv_ge_one ||
		                    (burst_cnt_q == lirs_pkg::BURST_W'(lirs_pkg::MAX_BURST - 1));
		stat.out_free     = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= lirs_pkg::STEP_RESET;
			fmt_q       <= lirs_pkg::FMT_INT16;
			chan_cnt_q  <= lirs_pkg::CHAN_RESET;
			chan_idx_q  <= '0;
			have_left_q <= 1'b0;
			left_q      <= '0;
			phase_q     <= '0;
			burst_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					lirs_pkg::CFG_PHASE_STEP:    step_q     <= cfg_data[lirs_pkg::STEP_W-1:0];
					lirs_pkg::CFG_SAMPLE_FORMAT: fmt_q      <= cfg_data[0];
					lirs_pkg::CFG_CHANNEL_COUNT: chan_cnt_q <= cfg_data[lirs_pkg::CHAN_CNT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.take) chan_idx_q <= idx_next;
			if (cmd.skip) begin
				left_q      <= right_q;
				have_left_q <= 1'b1;
				if (have_left_q) phase_q <= phase_q - lirs_pkg::PHASE_ONE;
			end
			if (cmd.diff) burst_cnt_q <= '0;
			if (cmd.emit) begin
				burst_cnt_q <= burst_cnt_q + 1'b1;
				if (adv_ge_one)
					phase_q <= phase_adv - lirs_pkg::PHASE_ONE;
				else if (stat.burst_last)
					phase_q <= '0;
				else
					phase_q <= phase_adv;
				if (stat.burst_last) left_q <= right_q;
			end
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) word_q <= sample_word;
		if (cmd.cvt) begin
			fmag_q <= man_eff * lirs_pkg::FLT_SCALE;
			fexp_q <= w_exp;
			fneg_q <= word_q[31];
			fnan_q <= (w_exp == 8'hFF) && (w_man != '0);
			finf_q <= (w_exp == 8'hFF) && (w_man == '0);
		end
		if (cmd.sat) right_q <= right_d;
		if (cmd.diff) begin
			dmag_q <= diff_abs[lirs_pkg::Q8_W-1:0];
			dneg_q <= diff[lirs_pkg::Q8_W];
		end
		if (cmd.mul) prod_q <= dmag_q * phase_q[lirs_pkg::PHASE_FRAC_BITS-1:0];
		if (cmd.emit) begin
			pcm_q  <= pcm_d;
			last_q <= stat.burst_last;
		end
	end

endmodule

[rtl/core/linear_interp_resampler_unit.sv]
// Top level of the linear interpolation resampler: controller plus datapath.
//
// Input channel: sample_word with in_valid/in_stall, one interleaved channel
// word per beat. Only the channel 0 word of each frame is processed; other
// words are taken without stalling the input and give no output.
// Output channel: pcm_sample/last with out_valid/out_stall. Each processed
// frame gives zero to eight beats; last marks the final beat of a frame.
// Timing: a channel 0 word passes through conversion and decision, then a
// multiply step and an emit step per output beat on the shared
// difference-times-phase multiplier, so in_stall stays high until the frame
// is done; the first beat shows after conversion, decision and the first multiply.
// The output register lets the next word be accepted while the last beat of
// a frame waits. A stalled receiver holds the burst in its emit step.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 phase
// step Q5.20, 1 sample format, 2 channel count); write only when idle.
// Reset (arst_n low) restores default configuration, clears the phase,
// channel index and first-frame flag, and drops any pending output beat.
module linear_interp_resampler_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lirs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lirs_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [lirs_pkg::WORD_W-1:0]        sample_word,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [lirs_pkg::PCM_W-1:0]  pcm_sample,
	output logic                               last
);

	lirs_pkg::lirs_cmd_t  cmd;
	lirs_pkg::lirs_stat_t stat;

	lirs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	lirs_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.sample_word (sample_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pcm_sample  (pcm_sample),
		.last        (last),
		.cmd         (cmd),
		.stat        (stat)
	);

endmodule

[rtl/core/lirs_checker.sv]
// Port-level checks for the resampler, bound to the top level.
module lirs_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic signed [lirs_pkg::PCM_W-1:0]  pcm_sample,
	input logic                               last
);

	// a stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pcm_sample) && $stable(last))
		else $error("output beat changed under stall");

	// mid-burst beat on the output: the frame is still in progress
	a_burst_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> in_stall)
		else $error("input open before burst finished");

	// a fresh output beat only comes out of a busy cycle
	a_beat_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("output beat without processing");

	// an accepted beat with nothing behind it leaves the output empty when idle
	a_idle_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !in_stall |=> !out_valid)
		else $error("output beat appeared while idle");

endmodule

bind linear_interp_resampler_unit lirs_checker u_lirs_checker (.*);

[test/tb_linear_interp_resampler_unit.sv]
// Self-checking testbench for linear_interp_resampler_unit: directed script, then random frames.
module tb_linear_interp_resampler_unit;
	import lirs_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int SETTLE       = 24;
	localparam int RANDOM_WORDS = 240;
	localparam int PREDICT      = -1;
	localparam int SCRIPT_LEN   = 36;

	typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

	typedef struct {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [WORD_W-1:0]      data;
		int                     n_typed;
		logic signed [PCM_W-1:0] pcm;
	} row_t;

	typedef struct packed {
		logic signed [PCM_W-1:0] pcm;
		logic                    last;
	} pcm_beat_t;

	logic                    clk         = 1'b0;
	logic                    arst_n      = 1'b0;
	logic                    cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index   = CFG_PHASE_STEP;
	logic [CFG_DATA_W-1:0]   cfg_data    = '0;
	logic                    in_valid    = 1'b0;
	logic                    in_stall;
	logic [WORD_W-1:0]       sample_word = '0;
	logic                    out_valid;
	logic                    out_stall   = 1'b0;
	logic signed [PCM_W-1:0] pcm_sample;
	logic                    last;

	linear_interp_resampler_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_word(sample_word),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pcm_sample (pcm_sample),
		.last       (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// resampler state and registers as the block should hold them
	logic [STEP_W-1:0]       step_reg  = STEP_RESET;
	logic                    fmt_reg   = FMT_INT16;
	logic [CHAN_CNT_W-1:0]   chans_reg = CHAN_RESET;
	logic signed [Q8_W-1:0]  left_q8   = '0;
	logic                    have_left = 1'b0;
	logic [PHASE_W-1:0]      phase     = '0;
	logic [CHAN_W-1:0]       chan_idx  = '0;

	pcm_beat_t               pcm_due[$];
	pcm_beat_t               burst[$];
	int                      typed_n    = PREDICT;
	logic signed [PCM_W-1:0] typed_pcm  = '0;
	logic                    jitter_on  = 1'b1;
	int                      mismatches = 0;
	int                      pcm_checked = 0;
	int                      frames_in  = 0;
	int                      words_in   = 0;
	int                      reg_writes = 0;
	int                      cycles     = 0;
	int                      stall_run  = 0;

	function automatic logic signed [Q8_W-1:0] word_to_q8(input logic [WORD_W-1:0] w);
		int                  ex;
		int                  sh;
		longint unsigned     man;
		longint unsigned     mag;
		longint unsigned     lim;
		logic [Q8_W-1:0]     q;
		if (fmt_reg == FMT_INT16)
			return {{8{w[15]}}, w[15:0], 8'h00};
		ex  = int'(w[30:23]);
		man = longint'(w[22:0]);
		lim = w[31] ? 64'h8000_0000 : 64'h7FFF_FFFF;
		if (ex == 255) begin
			// NaN reads as silence, infinities pin to the rail
			if (man != 0)
				return '0;
			mag = lim;
		end else begin
			if (ex == 0)
				ex = 1;
			else
				man = man | 64'h80_0000;
			mag = man * longint'(FLT_SCALE);
			sh  = ex - int'(FLT_EXP_BIAS);
			if (sh >= 0) begin
				if (mag != 0 && (sh > 31 || mag > (lim >> sh)))
					mag = lim;
				else
					mag = mag << sh;
			end else begin
				mag = (-sh >= 64) ? 64'd0 : (mag >> (-sh));
			end
			if (mag > lim)
				mag = lim;
		end
		q = mag[31:0];
		return w[31] ? -q : q;
	endfunction

	function automatic logic signed [PCM_W-1:0] lerp_pcm(input logic signed [Q8_W-1:0] right,
			input logic [PHASE_W-1:0] frac);
		longint          d;
		longint          v;
		longint          r;
		longint unsigned dm;
		longint unsigned m;
		d  = longint'(right) - longint'(left_q8);
		dm = (d < 0) ? -d : d;
		// truncate the magnitude, then apply the sign
		m  = (dm * frac) >> PHASE_FRAC_BITS;
		v  = longint'(left_q8) + ((d < 0) ? -longint'(m) : longint'(m));
		if (v > longint'(OUT_HI_Q8))
			v = longint'(OUT_HI_Q8);
		if (v < longint'(OUT_LO_Q8))
			v = longint'(OUT_LO_Q8);
		r = (v >= 0) ? (v + 128) / 256 : -((-v + 128) / 256);
		return r[15:0];
	endfunction

	// advance the predicted state by one word; burst gets the beats it causes
	task automatic resample_word(input logic [WORD_W-1:0] w);
		int                     cc;
		int                     idx;
		int                     n;
		longint unsigned        nxt;
		logic signed [Q8_W-1:0] right;
		burst.delete();
		cc = int'(chans_reg);
		if (cc == 0)
			cc = 1;
		if (cc > MAX_CHANNELS)
			cc = MAX_CHANNELS;
		idx      = int'(chan_idx);
		chan_idx = (idx + 1 >= cc) ? '0 : CHAN_W'(idx + 1);
		if (idx != 0)
			return;
		frames_in++;
		right = word_to_q8(w);
		if (!have_left) begin
			left_q8   = right;
			have_left = 1'b1;
			return;
		end
		n = 0;
		while (phase < PHASE_ONE && n < MAX_BURST) begin
			burst.push_back('{pcm: lerp_pcm(right, phase), last: 1'b0});
			nxt   = longint'(phase) + longint'(step_reg);
			phase = (nxt > longint'(PHASE_MAX)) ? PHASE_MAX : nxt[PHASE_W-1:0];
			n++;
		end
		if (n > 0)
			burst[n-1].last = 1'b1;
		// a burst cut off below one restarts the phase at zero
		phase   = (phase >= PHASE_ONE) ? phase - PHASE_ONE : '0;
		left_q8 = right;
	endtask

	always @(posedge clk) begin : watch
		pcm_beat_t due;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				pcm_checked++;
				if (pcm_due.size() == 0) begin
					$display("%0t: pcm beat %0d last %b with none pending", $time,
						pcm_sample, last);
					mismatches++;
				end else begin
					due = pcm_due.pop_front();
					if (pcm_sample !== due.pcm) begin
						$display("%0t: pcm_sample expected %0d got %0d", $time, due.pcm,
							pcm_sample);
						mismatches++;
					end
					if (last !== due.last) begin
						$display("%0t: last expected %b got %b", $time, due.last, last);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				resample_word(sample_word);
				if (typed_n == PREDICT) begin
					foreach (burst[k])
						pcm_due.push_back(burst[k]);
				end else if (typed_n == 1) begin
					pcm_due.push_back('{pcm: typed_pcm, last: 1'b1});
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: cycle limit reached, %0d beats still pending", $time,
				pcm_due.size());
			$display("simulation failed");
			$finish;
		end
	end

	function automatic int pick_gap();
		if (!jitter_on)
			return 0;
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: return 0;
			11, 12, 13, 14, 15, 16, 17: return $urandom_range(1, 3);
			default: return $urandom_range(8, 30);
		endcase
	endfunction

	// receiver back-pressure: alternate free and stalled runs
	always @(negedge clk) begin
		if (stall_run > 0) begin
			stall_run = stall_run - 1;
		end else if (jitter_on && !out_stall && $urandom_range(0, 2) == 0) begin
			out_stall <= 1'b1;
			stall_run = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 30)
				: $urandom_range(0, 2);
		end else begin
			out_stall <= 1'b0;
			stall_run = jitter_on ? $urandom_range(0, 6) : 0;
		end
	end

	task automatic send_word(input logic [WORD_W-1:0] w, input int n_typed,
			input logic signed [PCM_W-1:0] pcm);
		@(negedge clk);
		typed_n     = n_typed;
		typed_pcm   = pcm;
		in_valid    <= 1'b1;
		sample_word <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_in++;
	endtask

	task automatic idle_in(input int n);
		if (n > 0) begin
			@(negedge clk);
			in_valid    <= 1'b0;
			sample_word <= $urandom;
			repeat (n - 1)
				@(negedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_PHASE_STEP:    step_reg  = val[STEP_W-1:0];
			CFG_SAMPLE_FORMAT: fmt_reg   = val[0];
			CFG_CHANNEL_COUNT: chans_reg = val[CHAN_CNT_W-1:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// drop valid and let the block drain before touching a register
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pcm_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE)
			@(posedge clk);
	endtask

	function automatic logic [WORD_W-1:0] sample_value();
		logic [WORD_W-1:0] w;
		w = $urandom;
		if (fmt_reg == FMT_INT16) begin
			case ($urandom_range(0, 7))
				0: w[15:0] = 16'h7FFF;
				1: w[15:0] = 16'h8000;
				default: ;
			endcase
		end else begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: w[30:23] = 8'($urandom_range(112, 127));
				5: w[30:23] = 8'($urandom_range(127, 129));
				6: w[30:23] = 8'($urandom_range(143, 200));
				7: w[30:23] = 8'h00;
				8: begin
					w[30:23] = 8'hFF;
					if ($urandom_range(0, 1) == 0)
						w[22:0] = '0;
				end
				default: ;
			endcase
		end
		return w;
	endfunction

	task automatic send_frame(input int words);
		for (int ch = 0; ch < words; ch++) begin
			send_word((ch == 0) ? sample_value() : $urandom, PREDICT, '0);
			idle_in(pick_gap());
		end
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_step();
		case ($urandom_range(0, 7))
			0, 1: return CFG_DATA_W'($urandom_range(131072, 1048576));
			2, 3: return CFG_DATA_W'($urandom_range(786432, 1310720));
			4: return CFG_DATA_W'($urandom_range(131072, 16777216));
			5: return CFG_DATA_W'($urandom);
			6: begin
				case ($urandom_range(0, 5))
					0: return 25'd131072;
					1: return 25'd16777216;
					2: return '1;
					3: return '0;
					4: return 25'd1;
					default: return 25'd1048576;
				endcase
			end
			default: return CFG_DATA_W'($urandom_range(1048576, 4194304));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_chans();
		logic [CFG_DATA_W-1:0] junk;
		junk = CFG_DATA_W'($urandom) & ~25'hF;
		case ($urandom_range(0, 19))
			12, 13, 14, 15, 16: return junk | 25'($urandom_range(2, 3));
			17: return junk;
			18: return junk | 25'd8;
			19: return junk | 25'($urandom_range(9, 15));
			default: return junk | 25'd1;
		endcase
	endfunction

	initial begin
		row_t script [SCRIPT_LEN];
		int   goal;
		int   cc;
		int   guard;
		script = '{
			// after reset: unit step, one output per frame equal to the previous frame
			'{ROW_WORD, CFG_PHASE_STEP, 32'h0000_7FFF, 0, 16'sd0},
			'{ROW_WORD, CFG_PHASE_STEP, 32'h0000_8000, 1, 16'sh7FFF},
			'{ROW_WORD, CFG_PHASE_STEP, 32'hFFFF_0000, 1, 16'sh8000},
			'{ROW_WORD, CFG_PHASE_STEP, 32'h1234_0001, 1, 16'sd0},
			'{ROW_WORD, CFG_PHASE_STEP, 32'h0000_FFFF, 1, 16'sd1},
			// full eight-beat bursts, then a burst cut off short of one
			'{ROW_CFG, CFG_PHASE_STEP, 32'h0002_0000, PREDICT, 16'sd0},
			'{ROW_WORD, CFG_PHASE_STEP, 32'h0000_7FFF, PREDICT, 16'sd0},
			'{ROW_WORD, CFG_PHASE_STEP, 32'h0000_8000, PREDICT, 16'sd0},
			'{ROW_CFG, CFG_PHASE_STEP, 32'h0001_0000, PREDICT, 16'sd0},
			'{ROW_WORD, CFG_PHASE_STEP, 32'h0000_4000, PREDICT, 16'sd0},
			// float samples: unity, infinities, NaN, subnormal, huge
			'{ROW_CFG, CFG_PHASE_STEP, 32'h0010_0000, PREDICT, 16'sd0},
			'{ROW_CFG, CFG_SAMPLE_FORMAT, 32'(FMT_FLOAT32), PREDICT, 16'sd0},
			'{ROW_WORD, CFG_PHASE_STEP, 32'h3F80_0000, PREDICT, 16'sd0},
			'{ROW_WORD, CFG_PHASE_STEP, 32'hBF80_0000, PREDICT, 16'sd0},
			'{ROW_WORD, CFG_PHASE_STEP, 32'h7F80_0000, PREDICT, 16'sd0},
			'{ROW_WORD, CFG_PHASE_STEP, 32'hFF80_0000, PREDICT, 16'sd0},
			'{ROW_WORD, CFG_PHASE_STEP, 32'h7FC0_0000, PREDICT, 16'sd0},
			'{ROW_WORD, CFG_PHASE_STEP, 32'h0000_0001, PREDICT, 16'sd0},
			'{ROW_WORD, CFG_PHASE_STEP, 32'h4F00_0000, PREDICT, 16'sd0},
			// channel count clamped high, lowered mid-frame, zero
			'{ROW_CFG, CFG_SAMPLE_FORMAT, 32'(FMT_INT16), PREDICT, 16'sd0},
			'{ROW_CFG, CFG_CHANNEL_COUNT, 32'd15, PREDICT, 16'sd0},
			'{ROW_WORD, CFG_PHASE_STEP, 32'h0000_1111, PREDICT, 16'sd0},
			'{ROW_WORD, CFG_PHASE_STEP, 32'hABCD_1234, PREDICT, 16'sd0},
			'{ROW_WORD, CFG_PHASE_STEP, 32'h5555_AAAA, PREDICT, 16'sd0},
			'{ROW_CFG, CFG_CHANNEL_COUNT, 32'd1, PREDICT, 16'sd0},
			'{ROW_WORD, CFG_PHASE_STEP, 32'h0000_2222, PREDICT, 16'sd0},
			'{ROW_WORD, CFG_PHASE_STEP, 32'h0000_3333, PREDICT, 16'sd0},
			'{ROW_CFG, CFG_CHANNEL_COUNT, 32'd0, PREDICT, 16'sd0},
			'{ROW_WORD, CFG_PHASE_STEP, 32'h0000_4444, PREDICT, 16'sd0},
			// fractional phase, then saturation, then downsampling
			'{ROW_CFG, CFG_PHASE_STEP, 32'h000C_0000, PREDICT, 16'sd0},
			'{ROW_WORD, CFG_PHASE_STEP, 32'h0000_0100, PREDICT, 16'sd0},
			'{ROW_WORD, CFG_PHASE_STEP, 32'h0000_0200, PREDICT, 16'sd0},
			'{ROW_CFG, CFG_PHASE_STEP, 32'h01FF_FFFF, PREDICT, 16'sd0},
			'{ROW_WORD, CFG_PHASE_STEP, 32'h0000_0300, PREDICT, 16'sd0},
			'{ROW_CFG, CFG_PHASE_STEP, 32'h0100_0000, PREDICT, 16'sd0},
			'{ROW_WORD, CFG_PHASE_STEP, 32'h0000_0400, PREDICT, 16'sd0}
		};

		repeat (7)
			@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < SCRIPT_LEN; i++) begin
			if (script[i].kind == ROW_CFG) begin
				wait_idle();
				write_reg(script[i].idx, script[i].data[CFG_DATA_W-1:0]);
			end else begin
				send_word(script[i].data, script[i].n_typed, script[i].pcm);
				idle_in(pick_gap());
			end
		end

		// random settings, each followed by a run of mostly whole frames
		goal = words_in + RANDOM_WORDS;
		while (words_in < goal) begin
			wait_idle();
			write_reg(CFG_PHASE_STEP, pick_step());
			write_reg(CFG_SAMPLE_FORMAT, CFG_DATA_W'($urandom));
			write_reg(CFG_CHANNEL_COUNT, pick_chans());
			jitter_on = ($urandom_range(0, 3) != 0);
			cc = (chans_reg == 0) ? 1 : (chans_reg > MAX_CHANNELS) ? MAX_CHANNELS
				: int'(chans_reg);
			repeat ($urandom_range(15, 35)) begin
				if (words_in >= goal)
					break;
				if ($urandom_range(0, 11) == 0)
					send_frame($urandom_range(1, cc));
				else
					send_frame(cc);
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		guard = 0;
		while (pcm_due.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE)
			@(posedge clk);
		if (pcm_due.size() != 0) begin
			$display("%0t: %0d expected pcm beats never arrived", $time, pcm_due.size());
			mismatches += pcm_due.size();
		end

		$display("Fed %0d words, %0d of them channel 0, and checked %0d pcm beats",
			words_in, frames_in, pcm_checked);
		$display("across %0d register writes, %0d mismatches", reg_writes, mismatches);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/lirs_pkg.sv
rtl/core/lirs_ctrl.sv
rtl/core/lirs_datapath.sv
rtl/core/linear_interp_resampler_unit.sv
rtl/core/lirs_checker.sv
test/tb_linear_interp_resampler_unit.sv
